[rtl/multiwave_fm_oscillator_assert.svh]
// Assertion macros for the multiwave FM oscillator.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MULTIWAVE_FM_OSCILLATOR_ASSERT_SVH
`define MULTIWAVE_FM_OSCILLATOR_ASSERT_SVH
`ifndef SYNTH
`define MFO_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("multiwave_fm_oscillator: check failed");
`define MFO_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("multiwave_fm_oscillator: check failed");
`else
`define MFO_ASSERT(lbl, clk, rst, prop)
`define MFO_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/mfo_pkg.sv]
// Shared types, constants and the sine table function of the FM oscillator.
// No dependencies; imported by all files but mfo_ram and the assertion header.
package mfo_pkg;

  localparam int PHASE_BITS_DEF = 32;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int WIDTH_W = 16;
  localparam int STEP_W = 32;
  localparam int LFSR_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [SAMPLE_BITS-1:0] FS = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [SAMPLE_BITS-1:0] FS2 = SAMPLE_BITS'(2 * ((1 << (SAMPLE_BITS - 1)) - 1));
  localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(66);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(65470);
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    WAVE_SINE    = 3'd0,
    WAVE_SAW     = 3'd1,
    WAVE_PULSE   = 3'd2,
    WAVE_NOISE   = 3'd3,
    WAVE_IMPULSE = 3'd4,
    WAVE_OFF     = 3'd5
  } wave_code_t;

  typedef enum logic [2:0] {
    REG_MAIN_WAVE      = 3'd0,
    REG_MAIN_STEP      = 3'd1,
    REG_MAIN_WIDTH     = 3'd2,
    REG_FM_WAVE        = 3'd3,
    REG_FM_STEP        = 3'd4,
    REG_FM_WIDTH       = 3'd5,
    REG_FM_DEPTH       = 3'd6,
    REG_MODULATE_INPUT = 3'd7
  } reg_idx_t;

  localparam logic [STEP_W-1:0] MAIN_STEP_RST = 32'd19685267;
  localparam logic [STEP_W-1:0] FM_STEP_RST = 32'd26843546;
  localparam logic [WIDTH_W-1:0] WIDTH_RST = 16'd32768;
  localparam logic [31:0] FM_DEPTH_RST = 32'd1789570;

  typedef struct packed {
    logic [2:0]         main_wave;
    logic [STEP_W-1:0]  main_step;
    logic [WIDTH_W-1:0] main_width;
    logic [2:0]         fm_wave;
    logic [STEP_W-1:0]  fm_step;
    logic [WIDTH_W-1:0] fm_width;
    logic [31:0]        fm_depth;
    logic               modulate_input;
  } cfg_t;

  typedef struct packed {
    logic fill;
    logic load_in;
    logic mod_ph;
    logic car_ph;
    logic wave;
    logic sine;
    logic div_load;
    logic div_step;
    logic saw;
    logic fm_mul;
    logic in_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic fm_on;
    logic use_mod;
    logic wave_sine;
    logic wave_saw;
    logic div_last;
  } status_t;

  // Quarter-wave sine entry k for a table of 2^tbits entries, Q2.30 Taylor series.
  function automatic logic [SAMPLE_BITS-1:0] sine_entry(int unsigned k, int unsigned tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint unsigned v;
    begin
      x = (HALF_PI_Q30 * 64'(k)) >> tbits;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          default: term = term / 64'd156;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (longint'(sum) * 64'(FS) + (64'd1 << 29)) >> 30;
      if (v > 64'(FS)) begin
        v = 64'(FS);
      end
      return SAMPLE_BITS'(v);
    end
  endfunction

endpackage

[rtl/mfo_stream_if.sv]
// Sample stream interfaces of the FM oscillator: input audio and generated output.
// Depends on mfo_pkg for the sample width.
interface mfo_in_if import mfo_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface mfo_out_if import mfo_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface

[rtl/multiwave_fm_oscillator.sv]
// Top level of the multiwave FM oscillator: register file, controller, datapath.
// Depends on mfo_pkg, the stream interfaces, mfo_regs, mfo_ctrl and mfo_datapath.
//
// Usage: the audio channel carries one input sample per request; for each accepted
// request the tone channel delivers exactly one generated sample. Both channels use
// valid/ready; a request moves at a clock edge where both are high.
// Register i is at byte address 4*i on the APB-style port and reads back its current
// value. The user writes configuration only while idle; the block does not enforce.
// A request is taken in IDLE. With FM on, the modulator is evaluated first: its phase
// advances and its waveform, scaled by the FM depth, offsets the carrier step. The
// carrier phase then advances and its waveform is formed, multiplied by the input
// sample when modulate_input is set, and loaded into the output register. Sine adds
// a table read, saw a 16-step restoring divider (one quotient bit per cycle); saw
// modulating saw is slowest. A new request is taken in the cycle after a load.
// After reset the SINE_TABLE_DEPTH-entry sine RAM is filled from a constant table,
// one entry per cycle; audio.ready stays low until the fill is done.
// If the tone receiver stalls, the finished sample waits in the output register;
// the block still accepts the next request and holds its result until the slot frees.
module multiwave_fm_oscillator import mfo_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mfo_in_if.sink                audio,
  mfo_out_if.source             tone,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;
  logic    in_ready;
  logic    out_valid;

  mfo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (tone.ready),
    .st        (st),
    .cmd       (cmd)
  );

  mfo_datapath #(
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .st         (st),
    .in_sample  (audio.in_sample),
    .out_sample (tone.out_sample)
  );

  assign audio.ready = in_ready;
  assign tone.valid = out_valid;

endmodule

[rtl/mfo_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module mfo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mfo_regs.sv]
// APB-style configuration register file of the FM oscillator.
// Depends on mfo_pkg for the register map and the configuration struct.
module mfo_regs import mfo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.main_wave <= WAVE_SINE;
      cfg.main_step <= MAIN_STEP_RST;
      cfg.main_width <= WIDTH_RST;
      cfg.fm_wave <= WAVE_OFF;
      cfg.fm_step <= FM_STEP_RST;
      cfg.fm_width <= WIDTH_RST;
      cfg.fm_depth <= FM_DEPTH_RST;
      cfg.modulate_input <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_MAIN_WAVE:      cfg.main_wave <= pwdata[2:0];
        REG_MAIN_STEP:      cfg.main_step <= pwdata[STEP_W-1:0];
        REG_MAIN_WIDTH:     cfg.main_width <= pwdata[WIDTH_W-1:0];
        REG_FM_WAVE:        cfg.fm_wave <= pwdata[2:0];
        REG_FM_STEP:        cfg.fm_step <= pwdata[STEP_W-1:0];
        REG_FM_WIDTH:       cfg.fm_width <= pwdata[WIDTH_W-1:0];
        REG_FM_DEPTH:       cfg.fm_depth <= pwdata[31:0];
        REG_MODULATE_INPUT: cfg.modulate_input <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MAIN_WAVE:      prdata = CFG_DATA_W'(cfg.main_wave);
      REG_MAIN_STEP:      prdata = CFG_DATA_W'(cfg.main_step);
      REG_MAIN_WIDTH:     prdata = CFG_DATA_W'(cfg.main_width);
      REG_FM_WAVE:        prdata = CFG_DATA_W'(cfg.fm_wave);
      REG_FM_STEP:        prdata = CFG_DATA_W'(cfg.fm_step);
      REG_FM_WIDTH:       prdata = CFG_DATA_W'(cfg.fm_width);
      REG_FM_DEPTH:       prdata = CFG_DATA_W'(cfg.fm_depth);
      REG_MODULATE_INPUT: prdata = CFG_DATA_W'(cfg.modulate_input);
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/mfo_ctrl.sv]
// Sequencing state machine of the FM oscillator: table fill, modulator, carrier, output.
// Depends on mfo_pkg for the command and status structs and on the assertion macros.
`include "multiwave_fm_oscillator_assert.svh"

module mfo_ctrl import mfo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_FILL     = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_MOD_PH   = 12'b0000_0000_0100,
    S_CAR_PH   = 12'b0000_0000_1000,
    S_WAVE     = 12'b0000_0001_0000,
    S_SINE     = 12'b0000_0010_0000,
    S_DIV_LOAD = 12'b0000_0100_0000,
    S_DIV      = 12'b0000_1000_0000,
    S_SAW      = 12'b0001_0000_0000,
    S_FM_MUL   = 12'b0010_0000_0000,
    S_IN_MUL   = 12'b0100_0000_0000,
    S_OUT      = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_wave;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign after_wave = st.use_mod ? S_FM_MUL : S_IN_MUL;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_FILL:     if (st.fill_done) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = st.fm_on ? S_MOD_PH : S_CAR_PH;
      S_MOD_PH:   state_next = S_WAVE;
      S_CAR_PH:   state_next = S_WAVE;
      S_WAVE: begin
        if (st.wave_sine) begin
          state_next = S_SINE;
        end else if (st.wave_saw) begin
          state_next = S_DIV_LOAD;
        end else begin
          state_next = after_wave;
        end
      end
      S_SINE:     state_next = after_wave;
      S_DIV_LOAD: state_next = S_DIV;
      S_DIV:      if (st.div_last) state_next = S_SAW;
      S_SAW:      state_next = after_wave;
      S_FM_MUL:   state_next = S_CAR_PH;
      S_IN_MUL:   state_next = S_OUT;
      S_OUT:      if (slot_free) state_next = S_IDLE;
      default:    state_next = S_FILL;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.fill = (state == S_FILL);
    cmd.load_in = (state == S_IDLE) && in_valid;
    cmd.mod_ph = (state == S_MOD_PH);
    cmd.car_ph = (state == S_CAR_PH);
    cmd.wave = (state == S_WAVE);
    cmd.sine = (state == S_SINE);
    cmd.div_load = (state == S_DIV_LOAD);
    cmd.div_step = (state == S_DIV);
    cmd.saw = (state == S_SAW);
    cmd.fm_mul = (state == S_FM_MUL);
    cmd.in_mul = (state == S_IN_MUL);
    cmd.out_load = (state == S_OUT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MFO_ASSERT(a_accept_starts_phase, clk, rst, (in_valid && in_ready) |=> (state == S_MOD_PH || state == S_CAR_PH))
  `MFO_ASSERT(a_carrier_selected, clk, rst, (state == S_CAR_PH) |=> (state == S_WAVE && !st.use_mod))
  `MFO_ASSERT(a_fm_after_modulator, clk, rst, (state == S_FM_MUL) |-> st.use_mod)
  `MFO_ASSERT(a_result_shown, clk, rst, cmd.out_load |=> out_valid)
  `MFO_ASSERT_ALWAYS(a_ready_after_fill, clk, in_ready |-> st.fill_done)

endmodule

[rtl/mfo_datapath.sv]
// Datapath of the FM oscillator: phases, waveform logic, saw divider, multipliers, sine RAM.
// Depends on mfo_pkg and mfo_ram; driven by commands from mfo_ctrl.
module mfo_datapath import mfo_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  cmd_t                          cmd,
  output status_t                       st,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int TBITS = $clog2(SINE_TABLE_DEPTH);
  localparam int NUM_W = 32 + SAMPLE_BITS;
  localparam int FMP_W = SAMPLE_BITS + 32;
  localparam int OFF_W = FMP_W - SAMPLE_BITS + 1;
  localparam int SUM_W = STEP_W + 2;
  localparam int INP_W = 2 * SAMPLE_BITS;
  localparam int CNT_W = $clog2(SAMPLE_BITS);

  // Sine table contents, computed at elaboration and copied into the RAM after reset.
  logic [SINE_TABLE_DEPTH-1:0][SAMPLE_BITS-1:0] sine_rom;

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [SAMPLE_BITS-1:0] ENTRY = sine_entry(g, TBITS);
    assign sine_rom[g] = ENTRY;
  end

  logic [TBITS:0]                 fill_cnt;
  logic                           fill_we;
  logic [TBITS-1:0]               fill_addr;
  logic [SAMPLE_BITS-1:0]         fill_data;

  logic [PHASE_BITS-1:0]          mod_phase;
  logic [PHASE_BITS-1:0]          car_phase;
  logic [PHASE_BITS-1:0]          mod_last;
  logic [PHASE_BITS-1:0]          car_last;
  logic [LFSR_W-1:0]              lfsr;
  logic                           use_mod;

  logic signed [SAMPLE_BITS-1:0]  in_reg;
  logic signed [SAMPLE_BITS-1:0]  wave_val;
  logic [NUM_W-1:0]               saw_num;
  logic [WIDTH_W-1:0]             div_d;
  logic                           saw_lo_q;
  logic [WIDTH_W-1:0]             rem;
  logic [SAMPLE_BITS-1:0]         dq;
  logic [CNT_W-1:0]               div_cnt;
  logic [1:0]                     quad_q;
  logic                           idx_zero_q;
  logic signed [FMP_W-1:0]        fm_prod;
  logic signed [INP_W-1:0]        in_prod;

  logic [PHASE_BITS-1:0]          ph_sel;
  logic [PHASE_BITS-1:0]          last_sel;
  logic [31:0]                    frac;
  logic [2:0]                     code;
  logic [WIDTH_W-1:0]             width_sel;
  logic [WIDTH_W-1:0]             cw;
  logic [31:0]                    w32;
  logic                           saw_lo;
  logic [31:0]                    saw_diff;
  logic [TBITS-1:0]               sin_idx;
  logic [TBITS-1:0]               raddr;
  logic [SAMPLE_BITS-1:0]         rdata;
  logic [LFSR_W-1:0]              lfsr_next;
  logic signed [SAMPLE_BITS-1:0]  noise_val;
  logic signed [SAMPLE_BITS-1:0]  simple_val;
  logic [WIDTH_W:0]               trial;
  logic                           trial_ge;
  logic signed [SAMPLE_BITS-1:0]  sine_mag;
  logic signed [SAMPLE_BITS:0]    saw_val;
  logic signed [31:0]             depth_s;
  logic signed [OFF_W-1:0]        fm_off;
  logic [SUM_W-1:0]               step_sum;
  logic [PHASE_BITS-1:0]          car_inc;
  logic [PHASE_BITS-1:0]          mod_inc;
  logic [SAMPLE_BITS:0]           prod_sh;
  logic signed [SAMPLE_BITS-1:0]  samp;

  assign ph_sel = use_mod ? mod_phase : car_phase;
  assign last_sel = use_mod ? mod_last : car_last;
  assign code = use_mod ? cfg.fm_wave : cfg.main_wave;
  assign width_sel = use_mod ? cfg.fm_width : cfg.main_width;

  if (PHASE_BITS >= 32) begin : g_frac_down
    assign frac = ph_sel[PHASE_BITS-1 -: 32];
  end else begin : g_frac_up
    assign frac = {ph_sel, {(32 - PHASE_BITS){1'b0}}};
  end

  if (PHASE_BITS <= SUM_W) begin : g_step_trunc
    assign car_inc = step_sum[PHASE_BITS-1:0];
  end else begin : g_step_ext
    assign car_inc = {{(PHASE_BITS - SUM_W){step_sum[SUM_W-1]}}, step_sum};
  end

  if (PHASE_BITS <= STEP_W) begin : g_mod_trunc
    assign mod_inc = cfg.fm_step[PHASE_BITS-1:0];
  end else begin : g_mod_ext
    assign mod_inc = {{(PHASE_BITS - STEP_W){1'b0}}, cfg.fm_step};
  end

  always_comb begin
    if (width_sel < WIDTH_MIN) begin
      cw = WIDTH_MIN;
    end else if (width_sel > WIDTH_MAX) begin
      cw = WIDTH_MAX;
    end else begin
      cw = width_sel;
    end
  end

  assign w32 = {cw, 16'h0000};
  assign saw_lo = frac < w32;
  assign saw_diff = saw_lo ? frac : frac - w32;

  // Quarter-wave lookup: odd quadrants read the table mirrored.
  assign sin_idx = frac[29 -: TBITS];
  assign raddr = frac[30] ? TBITS'(-sin_idx) : sin_idx;

  assign lfsr_next = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);

  always_comb begin
    noise_val = lfsr_next[LFSR_W-1 -: SAMPLE_BITS];
    if (noise_val == {1'b1, {(SAMPLE_BITS - 1){1'b0}}}) begin
      noise_val = -$signed(FS);
    end
  end

  always_comb begin
    case (code)
      WAVE_PULSE:   simple_val = saw_lo ? $signed(FS) : -$signed(FS);
      WAVE_NOISE:   simple_val = noise_val;
      WAVE_IMPULSE: simple_val = (ph_sel < last_sel) ? $signed(FS) : '0;
      default:      simple_val = '0;
    endcase
  end

  assign trial = {rem, dq[SAMPLE_BITS-1]};
  assign trial_ge = trial >= {1'b0, div_d};

  assign sine_mag = (quad_q[0] && idx_zero_q) ? $signed(FS) : $signed(rdata);
  assign saw_val = saw_lo_q ? $signed({1'b0, dq}) - $signed({1'b0, FS})
                            : $signed({1'b0, FS}) - $signed({1'b0, dq});

  assign depth_s = cfg.fm_depth;
  assign fm_off = st.fm_on ? fm_prod[FMP_W-1:SAMPLE_BITS-1] : '0;
  assign step_sum = {2'b00, cfg.main_step} + SUM_W'(fm_off);

  assign prod_sh = in_prod[INP_W-1:SAMPLE_BITS-1];

  always_comb begin
    if (!cfg.modulate_input) begin
      samp = wave_val;
    end else if (prod_sh[SAMPLE_BITS] != prod_sh[SAMPLE_BITS-1]) begin
      samp = prod_sh[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else begin
      samp = prod_sh[SAMPLE_BITS-1:0];
    end
  end

  assign st.fill_done = (fill_cnt == (TBITS + 1)'(SINE_TABLE_DEPTH)) && !fill_we;
  assign st.fm_on = cfg.fm_wave <= WAVE_IMPULSE;
  assign st.use_mod = use_mod;
  assign st.wave_sine = code == WAVE_SINE;
  assign st.wave_saw = code == WAVE_SAW;
  assign st.div_last = div_cnt == CNT_W'(SAMPLE_BITS - 1);

  mfo_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      fill_we <= 1'b0;
      mod_phase <= '0;
      car_phase <= '0;
      mod_last <= '1;
      car_last <= '1;
      lfsr <= LFSR_SEED;
      use_mod <= 1'b0;
    end else begin
      fill_we <= 1'b0;
      if (cmd.fill && fill_cnt != (TBITS + 1)'(SINE_TABLE_DEPTH)) begin
        fill_we <= 1'b1;
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (cmd.mod_ph) begin
        mod_phase <= mod_phase + mod_inc;
        use_mod <= 1'b1;
      end
      if (cmd.car_ph) begin
        car_phase <= car_phase + car_inc;
        use_mod <= 1'b0;
      end
      if (cmd.wave) begin
        case (code)
          WAVE_NOISE: lfsr <= lfsr_next;
          WAVE_IMPULSE: begin
            if (use_mod) begin
              mod_last <= ph_sel;
            end else begin
              car_last <= ph_sel;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_addr <= fill_cnt[TBITS-1:0];
    fill_data <= sine_rom[fill_cnt[TBITS-1:0]];
    if (cmd.load_in) begin
      in_reg <= in_sample;
    end
    if (cmd.wave) begin
      wave_val <= simple_val;
      saw_num <= NUM_W'(saw_diff) * NUM_W'(FS2);
      div_d <= saw_lo ? cw : WIDTH_W'((WIDTH_W + 1)'(1 << WIDTH_W) - (WIDTH_W + 1)'(cw));
      saw_lo_q <= saw_lo;
      quad_q <= frac[31:30];
      idx_zero_q <= sin_idx == '0;
    end
    if (cmd.sine) begin
      wave_val <= quad_q[1] ? -sine_mag : sine_mag;
    end
    if (cmd.div_load) begin
      rem <= saw_num[NUM_W-1 -: WIDTH_W];
      dq <= saw_num[NUM_W-WIDTH_W-1 -: SAMPLE_BITS];
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? WIDTH_W'(trial - {1'b0, div_d}) : trial[WIDTH_W-1:0];
      dq <= {dq[SAMPLE_BITS-2:0], trial_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.saw) begin
      wave_val <= saw_val[SAMPLE_BITS-1:0];
    end
    if (cmd.fm_mul) begin
      fm_prod <= FMP_W'(wave_val) * FMP_W'(depth_s);
    end
    if (cmd.in_mul) begin
      in_prod <= INP_W'(wave_val) * INP_W'(in_reg);
    end
    if (cmd.out_load) begin
      out_sample <= samp;
    end
  end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the multiwave FM oscillator: directed and random settings
// and audio requests, each result checked against a cycle-free model in the testbench.
// Depends on mfo_pkg, the stream interfaces and the multiwave_fm_oscillator top level.
module testbench;
  import mfo_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 300000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned ERR_PRINT_MAX = 40;
  localparam longint PEAK = 32767;
  localparam logic [2:0] WAVE_SPARE6 = 3'd6;
  localparam logic [2:0] WAVE_SPARE7 = 3'd7;

  bit clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  mfo_in_if audio_if();
  mfo_out_if tone_if();

  multiwave_fm_oscillator u_top (
    .clk(clk),
    .rst(rst),
    .audio(audio_if),
    .tone(tone_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  cfg_t osc_cfg;
  logic [31:0] car_ph;
  logic [31:0] mod_ph;
  logic [31:0] car_last;
  logic [31:0] mod_last;
  logic [31:0] noise_reg;
  logic [15:0] sine_quarter [0:1023];

  logic [15:0] audio_backlog [$];
  logic [15:0] tone_expected [$];
  bit audio_took;
  bit tx_hold;
  bit rx_hold;
  int unsigned in_idle;
  int unsigned out_idle;
  int unsigned n_taken;
  int unsigned n_err;
  int unsigned cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint shape(logic [2:0] sel, logic [31:0] ph, logic [15:0] width,
                                   bit is_mod);
    longint unsigned f;
    longint unsigned w;
    logic [15:0] wc;
    int idx;
    longint v;
    f = {32'd0, ph};
    wc = (width < WIDTH_MIN) ? WIDTH_MIN : ((width > WIDTH_MAX) ? WIDTH_MAX : width);
    w = {32'd0, wc, 16'd0};
    v = 0;
    case (sel)
      WAVE_SINE: begin
        idx = int'(ph[29:20]);
        if (ph[30]) begin
          v = (idx == 0) ? PEAK : longint'(sine_quarter[1024 - idx]);
        end else begin
          v = longint'(sine_quarter[idx]);
        end
        if (ph[31]) begin
          v = -v;
        end
      end
      WAVE_SAW: begin
        if (f < w) begin
          v = longint'((64'd2 * f * 64'd32767) / w) - PEAK;
        end else begin
          v = PEAK - longint'((64'd2 * (f - w) * 64'd32767) / ((64'd1 << 32) - w));
        end
      end
      WAVE_PULSE: begin
        v = (f < w) ? PEAK : -PEAK;
      end
      WAVE_NOISE: begin
        noise_reg = {1'b0, noise_reg[31:1]} ^ (noise_reg[0] ? LFSR_TAPS : 32'd0);
        v = longint'(signed'(noise_reg[31:16]));
        if (v < -PEAK) begin
          v = -PEAK;
        end
      end
      WAVE_IMPULSE: begin
        if (is_mod) begin
          v = (ph < mod_last) ? PEAK : 0;
          mod_last = ph;
        end else begin
          v = (ph < car_last) ? PEAK : 0;
          car_last = ph;
        end
      end
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] next_tone(logic signed [15:0] smp);
    longint step_sum;
    longint depth;
    longint m;
    longint s;
    longint x;
    step_sum = {32'd0, osc_cfg.main_step};
    if (osc_cfg.fm_wave < WAVE_OFF) begin
      depth = signed'(osc_cfg.fm_depth);
      mod_ph = mod_ph + osc_cfg.fm_step;
      m = shape(osc_cfg.fm_wave, mod_ph, osc_cfg.fm_width, 1'b1);
      step_sum = step_sum + ((m * depth) >>> 15);
    end
    car_ph = car_ph + step_sum[31:0];
    s = shape(osc_cfg.main_wave, car_ph, osc_cfg.main_width, 1'b0);
    if (osc_cfg.modulate_input) begin
      x = smp;
      s = (s * x) >>> 15;
    end
    if (s > PEAK) begin
      s = PEAK;
    end
    if (s < -PEAK - 1) begin
      s = -PEAK - 1;
    end
    return s[15:0];
  endfunction

  task automatic report_error(string msg);
    if (n_err < ERR_PRINT_MAX) begin
      $display("error at cycle %0d: %s", cycles, msg);
    end
    n_err++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      audio_if.valid <= 1'b0;
    end else if (!audio_if.valid || audio_took) begin
      if (audio_backlog.size() != 0 && !tx_hold && $urandom_range(99) >= in_idle) begin
        audio_if.valid <= 1'b1;
        audio_if.in_sample <= audio_backlog.pop_front();
      end else begin
        audio_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    tone_if.ready <= !rx_hold && ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("multiwave_fm_oscillator: mismatch");
      $finish;
    end else begin
      audio_took = !rst && audio_if.valid && audio_if.ready;
      if (audio_took) begin
        tone_expected.push_back(next_tone(audio_if.in_sample));
        n_taken++;
      end
      if (!rst && tone_if.valid && tone_if.ready) begin
        if (tone_expected.size() == 0) begin
          report_error($sformatf("out_sample %h with no request pending", tone_if.out_sample));
        end else begin
          if (tone_if.out_sample !== tone_expected[0]) begin
            report_error($sformatf("out_sample got %h expected %h",
                                   tone_if.out_sample, tone_expected[0]));
          end
          void'(tone_expected.pop_front());
        end
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_MAIN_WAVE: osc_cfg.main_wave = val[2:0];
      REG_MAIN_STEP: osc_cfg.main_step = val;
      REG_MAIN_WIDTH: osc_cfg.main_width = val[15:0];
      REG_FM_WAVE: osc_cfg.fm_wave = val[2:0];
      REG_FM_STEP: osc_cfg.fm_step = val;
      REG_FM_WIDTH: osc_cfg.fm_width = val[15:0];
      REG_FM_DEPTH: osc_cfg.fm_depth = val;
      REG_MODULATE_INPUT: osc_cfg.modulate_input = val[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    while (audio_backlog.size() != 0 || audio_if.valid || tone_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_width();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h0000_FFFF;
      2: return $urandom_range(200);
      3: return $urandom_range(32'h0000_FFFF, 32'h0000_FF80);
      default: return $urandom_range(32'h0000_FFFF);
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] depth;
    if ($urandom_range(9) < 8) begin
      cfg_write(REG_MAIN_WAVE, $urandom_range(int'(WAVE_IMPULSE)));
    end else begin
      cfg_write(REG_MAIN_WAVE, $urandom_range(int'(WAVE_SPARE7)));
    end
    cfg_write(REG_MAIN_STEP, pick_step());
    cfg_write(REG_MAIN_WIDTH, pick_width());
    cfg_write(REG_FM_WAVE, $urandom_range(int'(WAVE_SPARE7)));
    cfg_write(REG_FM_STEP, pick_step());
    cfg_write(REG_FM_WIDTH, pick_width());
    case ($urandom_range(4))
      0: depth = 32'h8000_0000;
      1: depth = 32'h7FFF_FFFF;
      2: depth = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: depth = $urandom;
    endcase
    cfg_write(REG_FM_DEPTH, depth);
    cfg_write(REG_MODULATE_INPUT, $urandom_range(1));
  endtask

  task automatic feed_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: audio_backlog.push_back(16'h8000);
        1: audio_backlog.push_back(16'h7FFF);
        default: audio_backlog.push_back($urandom);
      endcase
    end
  endtask

  initial begin
    while (n_taken < 120) @(posedge clk);
    rx_hold = 1'b1;
    for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint acc;
    longint unsigned v;
    for (int k = 0; k < 1024; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) / 64'd1024;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_quarter[k] = v[15:0];
    end
    car_ph = '0;
    mod_ph = '0;
    car_last = '1;
    mod_last = '1;
    noise_reg = LFSR_SEED;
    osc_cfg.main_wave = WAVE_SINE;
    osc_cfg.main_step = MAIN_STEP_RST;
    osc_cfg.main_width = WIDTH_RST;
    osc_cfg.fm_wave = WAVE_OFF;
    osc_cfg.fm_step = FM_STEP_RST;
    osc_cfg.fm_width = WIDTH_RST;
    osc_cfg.fm_depth = FM_DEPTH_RST;
    osc_cfg.modulate_input = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    audio_if.valid = 1'b0;
    audio_if.in_sample = '0;
    tone_if.ready = 1'b0;
    in_idle = 14;
    out_idle = 46;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    audio_backlog.push_back(16'h8000);
    audio_backlog.push_back(16'h7FFF);
    audio_backlog.push_back(16'h0000);
    audio_backlog.push_back(16'hFFFF);
    audio_backlog.push_back(16'h0001);
    settle();

    // Saw with the narrowest width and a step that runs the phase backward.
    cfg_write(REG_MAIN_WAVE, WAVE_SAW);
    cfg_write(REG_MAIN_WIDTH, 32'd0);
    cfg_write(REG_MAIN_STEP, 32'hFFFF_FFFF);
    feed_random(3);
    settle();

    cfg_write(REG_MAIN_WAVE, WAVE_PULSE);
    cfg_write(REG_MAIN_WIDTH, 32'h0000_FFFF);
    cfg_write(REG_MAIN_STEP, 32'h8000_0000);
    feed_random(3);
    settle();

    // Both oscillators on noise share one shift register.
    cfg_write(REG_MAIN_WAVE, WAVE_NOISE);
    cfg_write(REG_FM_WAVE, WAVE_NOISE);
    cfg_write(REG_FM_DEPTH, 32'h8000_0000);
    cfg_write(REG_FM_STEP, 32'hFFFF_FFFF);
    feed_random(3);
    settle();

    cfg_write(REG_MAIN_WAVE, WAVE_IMPULSE);
    cfg_write(REG_FM_WAVE, WAVE_IMPULSE);
    cfg_write(REG_FM_DEPTH, 32'h7FFF_FFFF);
    cfg_write(REG_MAIN_STEP, 32'h4000_0000);
    feed_random(4);
    settle();

    cfg_write(REG_MAIN_WAVE, WAVE_SPARE6);
    cfg_write(REG_FM_WAVE, WAVE_SPARE7);
    cfg_write(REG_MODULATE_INPUT, 32'd1);
    audio_backlog.push_back(16'h8000);
    audio_backlog.push_back(16'h7FFF);
    settle();

    cfg_write(REG_MAIN_WAVE, WAVE_SPARE7);
    cfg_write(REG_FM_WAVE, WAVE_SPARE6);
    feed_random(1);
    settle();

    // Saw modulating saw is the slowest path through the block.
    cfg_write(REG_MAIN_WAVE, WAVE_SAW);
    cfg_write(REG_FM_WAVE, WAVE_SAW);
    cfg_write(REG_FM_WIDTH, 32'd0);
    cfg_write(REG_FM_DEPTH, 32'h0010_0000);
    cfg_write(REG_FM_STEP, $urandom);
    cfg_write(REG_MODULATE_INPUT, 32'd0);
    feed_random(3);
    settle();

    cfg_write(REG_MAIN_WAVE, WAVE_SINE);
    cfg_write(REG_FM_WAVE, WAVE_SINE);
    cfg_write(REG_FM_WIDTH, 32'h0000_FFFF);
    cfg_write(REG_MODULATE_INPUT, 32'd1);
    audio_backlog.push_back(16'h8000);
    audio_backlog.push_back(16'h7FFF);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      in_idle = (phase == 0) ? 14 : ((phase == 1) ? 46 : 0);
      out_idle = (phase == 0) ? 46 : ((phase == 1) ? 14 : 0);
      for (int sec = 0; sec < 8; sec++) begin
        random_setup();
        feed_random(25);
        if (phase == 2 && sec == 3) begin
          while (audio_backlog.size() > 12) @(negedge clk);
          tx_hold = 1'b1;
          while (audio_if.valid || tone_expected.size() != 0) @(negedge clk);
          tx_hold = 1'b0;
        end
        settle();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("multiwave_fm_oscillator: match");
    end else begin
      $display("multiwave_fm_oscillator: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/mfo_pkg.sv
rtl/mfo_stream_if.sv
rtl/mfo_ram.sv
rtl/mfo_regs.sv
rtl/mfo_ctrl.sv
rtl/mfo_datapath.sv
rtl/multiwave_fm_oscillator.sv
verif/testbench.sv
